### sv/asfp_pkg.sv
package asfp_pkg;

	localparam int NUM_CH = 8;
	localparam int POS_W = 7;
	localparam int BYTE_W = 8;
	localparam int CNT_W = 32;

	localparam logic [BYTE_W-1:0] START_MARK = 8'h24;   // '$'
	localparam logic [BYTE_W-1:0] END_MARK = 8'h23;     // '#'
	localparam logic [BYTE_W-1:0] TYPE_DIGITAL = 8'h44; // 'D'
	localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;   // '0'

	localparam int FIRST_DIGIT_POS = 6;
	localparam int DIGIT_STRIDE = 5;
	localparam logic [POS_W-1:0] TYPE_POS = 7'd1;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic [NUM_CH-1:0][BYTE_W-1:0] level;
		logic [CNT_W-1:0]              frame_number;
	} result_t;

	typedef struct packed {
		logic             in_frame;
		logic [POS_W-1:0] pos;
	} status_t;

endpackage

### sv/asfp_in_stage.sv
module asfp_in_stage import asfp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  byte_t rx_byte,
	input  logic  advance,
	output logic  valid_s1,
	output byte_t byte_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

### sv/asfp_core.sv
module asfp_core import asfp_pkg::*; #(
	parameter int MAX_FRAME_LEN = 100,
	parameter int CHANNELS = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  byte_t   byte_s1,
	output logic    emit,
	output result_t result,
	output status_t status
);

	logic                 in_frame_q;
	logic [POS_W-1:0]     pos_q;
	byte_t                type_q;
	byte_t                dig_q [CHANNELS];
	logic [CNT_W-1:0]     frames_q;

	logic                 is_start;
	logic                 is_end;
	logic [POS_W:0]       next_pos;
	logic                 at_limit;
	byte_t                type_new;
	byte_t                dig_new [CHANNELS];

	assign is_start = (byte_s1 == START_MARK);
	assign is_end = (byte_s1 == END_MARK);
	assign next_pos = {1'b0, pos_q} + (POS_W+1)'(1);
	assign at_limit = (next_pos >= (POS_W+1)'(MAX_FRAME_LEN));

	// a byte lands in the capture before the close is judged
	assign type_new = (pos_q == TYPE_POS) ? byte_s1 : type_q;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			dig_new[i] = (pos_q == POS_W'(FIRST_DIGIT_POS + i * DIGIT_STRIDE)) ?
				byte_s1 : dig_q[i];
		end
	end

	assign emit = !is_start && in_frame_q && is_end && (type_new == TYPE_DIGITAL);

	genvar g;
	generate
		for (g = 0; g < NUM_CH; g++) begin : g_lvl
			if (g < CHANNELS) begin : g_used
				assign result.level[g] = dig_new[g] - ASCII_ZERO;
			end else begin : g_unused
				assign result.level[g] = '0;
			end
		end
	endgenerate

	assign result.frame_number = frames_q + CNT_W'(1);

	assign status.in_frame = in_frame_q;
	assign status.pos = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q <= '0;
			type_q <= '0;
			frames_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				dig_q[i] <= '0;
			end
		end else if (fire) begin
			if (is_start) begin
				// restart keeps the capture
				in_frame_q <= 1'b1;
				pos_q <= TYPE_POS;
			end else if (in_frame_q) begin
				if (is_end || at_limit) begin
					in_frame_q <= 1'b0;
					pos_q <= '0;
					type_q <= '0;
					for (int i = 0; i < CHANNELS; i++) begin
						dig_q[i] <= '0;
					end
					if (emit) begin
						frames_q <= result.frame_number;
					end
				end else begin
					pos_q <= next_pos[POS_W-1:0];
					type_q <= type_new;
					for (int i = 0; i < CHANNELS; i++) begin
						dig_q[i] <= dig_new[i];
					end
				end
			end
		end
	end

endmodule

### sv/asfp_out_reg.sv
module asfp_out_reg import asfp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t result_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

### sv/ascii_sensor_frame_parser_top.sv
// ASCII sensor frame parser. Takes one received byte per request on the input
// channel. A '$' opens (or restarts) a frame; bytes then go to positions 1, 2, ...
// and a '#' closes the frame. A closed frame whose position-1 byte is 'D' gives one
// result request: CHANNELS levels, each the byte at position 6+5i minus '0'
// (mod 256; unused channels read 0), and a wrapping 32-bit count of such frames.
// Other frames give nothing. A frame reaching MAX_FRAME_LEN positions is dropped.
// Captured bytes clear after close or abort but survive a restart.
// Timing: one byte per cycle sustained. A byte is held in the input register,
// is parsed by the single-pass frame logic and, if it closes a valid frame,
// lands in the result register. The result register stalls the parse stage
// only while a result is held unread.
module ascii_sensor_frame_parser_top import asfp_pkg::*; #(
	parameter int MAX_FRAME_LEN = 100,
	parameter int CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_W-1:0]     rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [BYTE_W-1:0]     ch0_level,
	output logic [BYTE_W-1:0]     ch1_level,
	output logic [BYTE_W-1:0]     ch2_level,
	output logic [BYTE_W-1:0]     ch3_level,
	output logic [BYTE_W-1:0]     ch4_level,
	output logic [BYTE_W-1:0]     ch5_level,
	output logic [BYTE_W-1:0]     ch6_level,
	output logic [BYTE_W-1:0]     ch7_level,
	output logic [CNT_W-1:0]      frame_number
);

	logic    valid_s1;
	byte_t   byte_s1;
	logic    advance;
	logic    emit;
	logic    load;
	result_t result;
	result_t result_q;
	status_t status;

	// parse stage moves when the result slot is free or draining this cycle
	assign advance = valid_s1 && (!out_valid || out_ready);
	assign load = advance && emit;

	asfp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	asfp_core #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN),
		.CHANNELS      (CHANNELS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.byte_s1 (byte_s1),
		.emit    (emit),
		.result  (result),
		.status  (status)
	);

	asfp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.result    (result),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_q  (result_q)
	);

	assign ch0_level = result_q.level[0];
	assign ch1_level = result_q.level[1];
	assign ch2_level = result_q.level[2];
	assign ch3_level = result_q.level[3];
	assign ch4_level = result_q.level[4];
	assign ch5_level = result_q.level[5];
	assign ch6_level = result_q.level[6];
	assign ch7_level = result_q.level[7];
	assign frame_number = result_q.frame_number;

`ifndef SYNTHESIS
	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!status.in_frame |-> status.pos == '0)
		else $error("position not cleared outside a frame");

	a_open_pos: assert property (@(posedge clk) disable iff (!arst_n)
		status.in_frame |-> (status.pos != '0) &&
			({1'b0, status.pos} < (POS_W+1)'(MAX_FRAME_LEN)))
		else $error("open frame position out of range");

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid || out_ready))
		else $error("result overwritten while held");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> frame_number == $past(result.frame_number))
		else $error("result count not captured");
`endif

endmodule
